// ----- sv/sjf_pkg.sv -----
`default_nettype none
package sjf_pkg;

	localparam int FUNC_W = 3;
	localparam int IDX_W  = 4;
	localparam int TIME_W = 16;
	localparam int STAT_W = 3;
	localparam int OCNT_W = 5;

	localparam logic [FUNC_W-1:0] FN_LOAD     = 3'd0;
	localparam logic [FUNC_W-1:0] FN_TICK     = 3'd1;
	localparam logic [FUNC_W-1:0] FN_FIRST    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SHORTEST = 3'd3;
	localparam logic [FUNC_W-1:0] FN_REMOVE   = 3'd4;

	localparam logic [STAT_W-1:0] STS_OK          = 3'd0;
	localparam logic [STAT_W-1:0] STS_TABLE_FULL  = 3'd1;
	localparam logic [STAT_W-1:0] STS_QUEUE_FULL  = 3'd2;
	localparam logic [STAT_W-1:0] STS_QUEUE_EMPTY = 3'd3;
	localparam logic [STAT_W-1:0] STS_NOT_QUEUED  = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_t;

endpackage
`default_nettype wire

// ----- sv/sjf_in_if.sv -----
`default_nettype none
interface sjf_in_if
	import sjf_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [IDX_W-1:0]  target_index;
	logic [TIME_W-1:0] arrival_time;
	logic [TIME_W-1:0] burst_length;
	logic [TIME_W-1:0] now_tick;

	modport source (output valid, func, target_index, arrival_time, burst_length, now_tick,
		input ready);
	modport sink (input valid, func, target_index, arrival_time, burst_length, now_tick,
		output ready);
endinterface
`default_nettype wire

// ----- sv/sjf_out_if.sv -----
`default_nettype none
interface sjf_out_if
	import sjf_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              found;
	logic [IDX_W-1:0]  proc_slot;
	logic [TIME_W-1:0] proc_arrival;
	logic [TIME_W-1:0] proc_burst;
	logic [STAT_W-1:0] status;
	logic [OCNT_W-1:0] queued_now;
	logic [OCNT_W-1:0] arrivals_added;

	modport source (output valid, found, proc_slot, proc_arrival, proc_burst, status,
		queued_now, arrivals_added, input ready);
	modport sink (input valid, found, proc_slot, proc_arrival, proc_burst, status,
		queued_now, arrivals_added, output ready);
endinterface
`default_nettype wire

// ----- sv/sjf_fifo_ready_queue_unit.sv -----
`default_nettype none
// Shortest-job-first ready queue: a process table plus an ordered queue of
// table indices, driven one command beat at a time.
// in_ch carries a command (load, tick, fetch first, fetch shortest, remove);
// out_ch returns exactly one result beat per command.
// One command is in flight at a time; in_ch.ready is high only while the
// sequencer is idle. Everything runs through one table RAM port and one
// queue RAM port with registered reads, so the scans are pipelined one
// entry per cycle. Load, an empty fetch and unused codes go straight to
// the result; tick scans the table and queues each entry whose arrival
// equals now_tick; fetch first takes the queue head, fetch shortest and
// remove scan the queue, and on a hit all three then close the gap.
// The result sits in an output register; a new command is taken while it
// waits, but the next result holds in the sequencer until out_ch drains.
// Reset clears the table and queue counts and the output valid; the RAM
// contents are not cleared and only written entries are ever read.
module sjf_fifo_ready_queue_unit
	import sjf_pkg::*;
#(
	parameter int TABLE_DEPTH = 16,
	parameter int QUEUE_DEPTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	sjf_in_if.sink   in_ch,
	sjf_out_if.source out_ch
);
	localparam int TIW  = $clog2(TABLE_DEPTH);
	localparam int QIW  = $clog2(QUEUE_DEPTH);
	localparam int TCW  = $clog2(TABLE_DEPTH + 1);
	localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
	localparam int CNTW = (TCW > QCW) ? TCW : QCW;
	localparam int TW   = 2 * TIME_W;

	state_t state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d, lim_q, lim_d;
	logic            v_s1, v1_d, v_s2, v2_d;
	logic [QIW-1:0]  pos_s1, pos1_d, pos_s2, pos2_d;
	logic [TIW-1:0]  idx_s1, idx1_d, slot_s2, slot2_d;
	logic [TCW-1:0]  tcount_q, tcount_d;
	logic [QCW-1:0]  qcount_q, qcount_d, added_q, added_d;
	logic            hit_q, hit_d, found_q, found_d;
	logic [STAT_W-1:0] status_q, status_d;
	logic [FUNC_W-1:0] op_q, op_d;
	logic [IDX_W-1:0]  tgt_q, tgt_d;
	logic [TIME_W-1:0] now_q, now_d;
	logic [QIW-1:0]    best_pos_q, best_pos_d;
	logic [TIW-1:0]    best_slot_q, best_slot_d;
	logic [TIME_W-1:0] best_arr_q, best_arr_d, best_bur_q, best_bur_d;
	logic              ov_q, ov_d, load_out;

	logic [TW-1:0]  t_rdata, t_wdata;
	logic [TIW-1:0] t_raddr, t_waddr, q_rdata, q_wdata;
	logic           t_we, q_we;
	logic [QIW-1:0] q_raddr, q_waddr;

	logic [IDX_W-1:0]    o_slot_q;
	logic [TIME_W-1:0]   o_arr_q, o_bur_q;
	logic [STAT_W-1:0]   o_status_q;
	logic [OCNT_W-1:0]   o_qnow_q, o_added_q;
	logic                o_found_q;
	logic [IDX_W+TIW-1:0]  slot_ext;
	logic [OCNT_W+QCW-1:0] qnow_ext, added_ext;
	logic                  accept, tgt_match;

	sjf_ram #(.WIDTH(TW), .DEPTH(TABLE_DEPTH)) u_table (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	sjf_ram #(.WIDTH(TIW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign tgt_match   = ({{TIW{1'b0}}, tgt_q} == {{IDX_W{1'b0}}, q_rdata});

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		lim_d       = lim_q;
		v1_d        = 1'b0;
		v2_d        = 1'b0;
		pos1_d      = pos_s1;
		pos2_d      = pos_s2;
		idx1_d      = idx_s1;
		slot2_d     = slot_s2;
		tcount_d    = tcount_q;
		qcount_d    = qcount_q;
		added_d     = added_q;
		hit_d       = hit_q;
		found_d     = found_q;
		status_d    = status_q;
		op_d        = op_q;
		tgt_d       = tgt_q;
		now_d       = now_q;
		best_pos_d  = best_pos_q;
		best_slot_d = best_slot_q;
		best_arr_d  = best_arr_q;
		best_bur_d  = best_bur_q;
		load_out    = 1'b0;
		t_we        = 1'b0;
		t_waddr     = tcount_q[TIW-1:0];
		t_wdata     = {in_ch.arrival_time, in_ch.burst_length};
		t_raddr     = cnt_q[TIW-1:0];
		q_we        = 1'b0;
		q_waddr     = qcount_q[QIW-1:0];
		q_wdata     = idx_s1;
		q_raddr     = cnt_q[QIW-1:0];

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_d        = in_ch.func;
					tgt_d       = in_ch.target_index;
					now_d       = in_ch.now_tick;
					found_d     = 1'b0;
					hit_d       = 1'b0;
					status_d    = STS_OK;
					added_d     = '0;
					best_slot_d = '0;
					best_arr_d  = '0;
					best_bur_d  = '0;
					cnt_d       = '0;
					state_d     = S_RESP;
					case (in_ch.func)
						FN_LOAD: begin
							if (tcount_q >= TCW'(TABLE_DEPTH)) begin
								status_d = STS_TABLE_FULL;
							end else begin
								t_we        = 1'b1;
								found_d     = 1'b1;
								best_slot_d = tcount_q[TIW-1:0];
								best_arr_d  = in_ch.arrival_time;
								best_bur_d  = in_ch.burst_length;
								tcount_d    = tcount_q + TCW'(1);
							end
						end
						FN_TICK: begin
							lim_d   = CNTW'(tcount_q);
							state_d = S_TICK;
						end
						FN_FIRST, FN_SHORTEST, FN_REMOVE: begin
							if (qcount_q == '0) begin
								status_d = (in_ch.func == FN_REMOVE) ? STS_NOT_QUEUED
									: STS_QUEUE_EMPTY;
							end else begin
								lim_d   = (in_ch.func == FN_FIRST) ? CNTW'(1) : CNTW'(qcount_q);
								state_d = S_SCAN;
							end
						end
						default: ;
					endcase
				end
			end

			S_TICK: begin
				if (cnt_q < lim_q) begin
					v1_d   = 1'b1;
					idx1_d = cnt_q[TIW-1:0];
					cnt_d  = cnt_q + CNTW'(1);
				end
				if (v_s1 && t_rdata[TW-1:TIME_W] == now_q) begin
					if (qcount_q >= QCW'(QUEUE_DEPTH)) begin
						status_d = STS_QUEUE_FULL;
					end else begin
						q_we     = 1'b1;
						qcount_d = qcount_q + QCW'(1);
						added_d  = added_q + QCW'(1);
					end
				end
				if (cnt_q >= lim_q && !v_s1) begin
					state_d = S_RESP;
				end
			end

			S_SCAN: begin
				// stage 0: queue read, stage 1: table read, stage 2: compare
				if (cnt_q < lim_q) begin
					v1_d   = 1'b1;
					pos1_d = cnt_q[QIW-1:0];
					cnt_d  = cnt_q + CNTW'(1);
				end
				t_raddr = q_rdata;
				if (v_s1) begin
					if (op_q == FN_REMOVE) begin
						if (!hit_q && tgt_match) begin
							hit_d      = 1'b1;
							best_pos_d = pos_s1;
						end
					end else begin
						v2_d    = 1'b1;
						pos2_d  = pos_s1;
						slot2_d = q_rdata;
					end
				end
				// strict less keeps the earliest queued entry on a tie
				if (v_s2 && (!hit_q || t_rdata[TIME_W-1:0] < best_bur_q)) begin
					hit_d       = 1'b1;
					best_pos_d  = pos_s2;
					best_slot_d = slot_s2;
					best_arr_d  = t_rdata[TW-1:TIME_W];
					best_bur_d  = t_rdata[TIME_W-1:0];
				end
				if (cnt_q >= lim_q && !v_s1 && !v_s2) begin
					if (hit_q) begin
						found_d = (op_q != FN_REMOVE);
						cnt_d   = CNTW'(best_pos_q) + CNTW'(1);
						state_d = S_SHIFT;
					end else begin
						status_d = STS_NOT_QUEUED;
						state_d  = S_RESP;
					end
				end
			end

			S_SHIFT: begin
				// close the gap: read k+1, then write it to k in the next cycle
				if (cnt_q < CNTW'(qcount_q)) begin
					v1_d   = 1'b1;
					pos1_d = QIW'(cnt_q - CNTW'(1));
					cnt_d  = cnt_q + CNTW'(1);
				end
				if (v_s1) begin
					q_we    = 1'b1;
					q_waddr = pos_s1;
					q_wdata = q_rdata;
				end
				if (cnt_q >= CNTW'(qcount_q) && !v_s1) begin
					qcount_d = qcount_q - QCW'(1);
					state_d  = S_RESP;
				end
			end

			S_RESP: begin
				if (!ov_q || out_ch.ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ov_d = ov_q;
		if (out_ch.ready) begin
			ov_d = 1'b0;
		end
		if (load_out) begin
			ov_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			lim_q    <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			tcount_q <= '0;
			qcount_q <= '0;
			hit_q    <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			lim_q    <= lim_d;
			v_s1     <= v1_d;
			v_s2     <= v2_d;
			tcount_q <= tcount_d;
			qcount_q <= qcount_d;
			hit_q    <= hit_d;
			ov_q     <= ov_d;
		end
	end

	assign slot_ext  = {{IDX_W{1'b0}}, best_slot_q};
	assign qnow_ext  = {{OCNT_W{1'b0}}, qcount_q};
	assign added_ext = {{OCNT_W{1'b0}}, added_q};

	always_ff @(posedge clk) begin
		pos_s1      <= pos1_d;
		pos_s2      <= pos2_d;
		idx_s1      <= idx1_d;
		slot_s2     <= slot2_d;
		added_q     <= added_d;
		found_q     <= found_d;
		status_q    <= status_d;
		op_q        <= op_d;
		tgt_q       <= tgt_d;
		now_q       <= now_d;
		best_pos_q  <= best_pos_d;
		best_slot_q <= best_slot_d;
		best_arr_q  <= best_arr_d;
		best_bur_q  <= best_bur_d;
		if (load_out) begin
			o_found_q  <= found_q;
			o_slot_q   <= slot_ext[IDX_W-1:0];
			o_arr_q    <= best_arr_q;
			o_bur_q    <= best_bur_q;
			o_status_q <= status_q;
			o_qnow_q   <= qnow_ext[OCNT_W-1:0];
			o_added_q  <= added_ext[OCNT_W-1:0];
		end
	end

	assign out_ch.valid          = ov_q;
	assign out_ch.found          = o_found_q;
	assign out_ch.proc_slot      = o_slot_q;
	assign out_ch.proc_arrival   = o_arr_q;
	assign out_ch.proc_burst     = o_bur_q;
	assign out_ch.status         = o_status_q;
	assign out_ch.queued_now     = o_qnow_q;
	assign out_ch.arrivals_added = o_added_q;

`ifndef SYNTHESIS
	a_qcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcount_q <= QCW'(QUEUE_DEPTH))
		else $error("queue count past depth");

	a_tcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tcount_q <= TCW'(TABLE_DEPTH))
		else $error("table count past depth");

	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SHIFT |-> qcount_q != '0)
		else $error("gap close on empty queue");

	a_s2_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> state_q == S_SCAN)
		else $error("compare stage live outside scan");

	a_resp_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESP && (!ov_q || out_ch.ready) |=> ov_q && state_q == S_IDLE)
		else $error("result not posted");
`endif
endmodule
`default_nettype wire

// ----- sv/sjf_ram.sv -----
`default_nettype none
module sjf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire
